// ===== hw/rtl/mcol_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-cost open list package
// Shared widths, operation codes, table entry type and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcol_pkg;

	localparam int ID_W      = 16;
	localparam int COST_W    = 32;
	localparam int DEPTH_DEF = 16;

	// Costs equal to this value are never picked by extract-min.
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Operation codes as they arrive on the input tuser.
	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_EXTRACT  = 2'd2,
		OP_CONTAINS = 2'd3
	} op_t;

	// What a table scan does with each entry it reads.
	typedef enum logic [1:0] {
		SCAN_MATCH,
		SCAN_MIN,
		SCAN_PURGE
	} scan_mode_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [COST_W-1:0] cost;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;          // capture the accepted beat
		logic       insert;        // append the captured entry
		logic       scan_start;    // start a pass over the table
		scan_mode_t scan_mode;
		logic       key_from_best; // purge key is the extracted id
		logic       result_load;   // move the result into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic have_min;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/mcol_ctrl.sv =====
// ----------------------------------------------------------------------------
// Min-cost open list controller
// Sequences one operation at a time: decode, up to two table scans, reply.
// ----------------------------------------------------------------------------
module mcol_ctrl
	import mcol_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_MIN,
		S_SCAN,
		S_REPLY
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands for the datapath.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.op)
					OP_INSERT: begin
						cmd.insert = 1'b1;
						state_d    = S_REPLY;
					end
					OP_REMOVE: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SCAN_PURGE;
						state_d        = S_SCAN;
					end
					OP_EXTRACT: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SCAN_MIN;
						state_d        = S_SCAN_MIN;
					end
					OP_CONTAINS: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SCAN_MATCH;
						state_d        = S_SCAN;
					end
					default: state_d = S_REPLY;
				endcase
			end
			S_SCAN_MIN: begin
				// After the minimum is known, purge every copy of its id.
				if (status.scan_done) begin
					if (status.have_min) begin
						cmd.scan_start    = 1'b1;
						cmd.scan_mode     = SCAN_PURGE;
						cmd.key_from_best = 1'b1;
						state_d           = S_SCAN;
					end else begin
						state_d = S_REPLY;
					end
				end
			end
			S_SCAN: begin
				if (status.scan_done) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				if (status.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/mcol_dp.sv =====
// ----------------------------------------------------------------------------
// Min-cost open list datapath
// Entry memory, entry count, scan engine with in-place compaction, and the
// output register.
// ----------------------------------------------------------------------------
module mcol_dp
	import mcol_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  logic [1:0]        in_op,
	input  logic [ID_W-1:0]   in_id,
	input  logic [COST_W-1:0] in_cost,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_found,
	output logic [ID_W-1:0]   out_id,
	output logic [COST_W-1:0] out_cost,
	output logic              out_is_empty,
	output logic              out_overflow
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Entry memory: one write port, one registered read port.
	entry_t mem_q [DEPTH];
	entry_t rdata_s1;

	// Captured operation.
	op_t               op_q;
	logic [ID_W-1:0]   key_q;
	logic [COST_W-1:0] cost_q;

	// Table occupancy and scan pointers.
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          active_q;
	logic          pend_s1;
	scan_mode_t    mode_q;

	// Operation results.
	logic              hit_q;
	logic              have_q;
	logic [ID_W-1:0]   best_id_q;
	logic [COST_W-1:0] best_cost_q;
	logic              ovf_q;
	logic              out_valid_q;

	logic          full;
	logic          issue;
	logic          done;
	logic          keep;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	assign full  = (count_q == CW'(DEPTH));
	assign issue = active_q && (rd_q != count_q);
	assign done  = active_q && !issue && !pend_s1;
	assign keep  = pend_s1 && (mode_q == SCAN_PURGE) && (rdata_s1.id != key_q);

	// Write port: append on insert, otherwise compaction writes.
	always_comb begin
		if (cmd.insert) begin
			wr_en        = !full;
			wr_addr      = count_q[AW-1:0];
			wr_data.id   = key_q;
			wr_data.cost = cost_q;
		end else begin
			wr_en   = active_q && keep;
			wr_addr = wr_q[AW-1:0];
			wr_data = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem_q[rd_q[AW-1:0]];
	end

	// Captured beat and purge key.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= in_id;
			cost_q <= in_cost;
		end else if (cmd.scan_start && cmd.key_from_best) begin
			key_q <= best_id_q;
		end
	end

	// Count, scan engine and per-operation flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_INSERT;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			active_q    <= 1'b0;
			pend_s1     <= 1'b0;
			mode_q      <= SCAN_MATCH;
			hit_q       <= 1'b0;
			have_q      <= 1'b0;
			best_id_q   <= '0;
			best_cost_q <= COST_MAX;
			ovf_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q        <= op_t'(in_op);
				hit_q       <= 1'b0;
				have_q      <= 1'b0;
				best_id_q   <= '0;
				best_cost_q <= COST_MAX;
				ovf_q       <= 1'b0;
			end
			if (cmd.insert) begin
				ovf_q <= full;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.scan_start) begin
				active_q <= 1'b1;
				rd_q     <= '0;
				wr_q     <= '0;
				pend_s1  <= 1'b0;
				mode_q   <= cmd.scan_mode;
			end else if (active_q) begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				pend_s1 <= issue;
				if (keep) begin
					wr_q <= wr_q + CW'(1);
				end
				// Look at the entry read in the previous cycle.
				if (pend_s1 && (mode_q == SCAN_MATCH) && (rdata_s1.id == key_q)) begin
					hit_q <= 1'b1;
				end
				if (pend_s1 && (mode_q == SCAN_MIN) && (rdata_s1.cost < best_cost_q)) begin
					best_cost_q <= rdata_s1.cost;
					best_id_q   <= rdata_s1.id;
					have_q      <= 1'b1;
				end
				if (done) begin
					active_q <= 1'b0;
					if (mode_q == SCAN_PURGE) begin
						count_q <= wr_q;
					end
				end
			end
		end
	end

	// Output register, free again once its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			out_found    <= (op_q == OP_CONTAINS) ? hit_q : ((op_q == OP_EXTRACT) && have_q);
			out_id       <= ((op_q == OP_EXTRACT) && have_q) ? best_id_q : '0;
			out_cost     <= ((op_q == OP_EXTRACT) && have_q) ? best_cost_q : '0;
			out_is_empty <= (count_q == '0);
			out_overflow <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	assign status.op        = op_q;
	assign status.scan_done = done;
	assign status.have_min  = have_q;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

// ===== hw/rtl/min_cost_open_list_top.sv =====
// ----------------------------------------------------------------------------
// Min-cost open list
// Open list for a path search: insert, remove by id, extract the lowest cost
// entry and membership query over an ordered table with a linear scan.
//
// Input channel s_*: one beat is one operation. s_tuser carries the
// operation code, s_tdata the node id and the 16.16 cost.
// Output channel m_*: exactly one beat per operation with found, id, cost,
// the empty flag and the overflow flag.
// Operations run one at a time. Insert appends without a scan; remove and
// contains take one scan over the table and extract up to two, one to find
// the minimum and one to purge its id. The scans read the single entry
// memory port once per cycle.
// A new beat is accepted as soon as the previous operation has put its
// result in the output register, even while that result is still waiting.
// When m_tready stays low the result is held and the controller waits with
// the next result, so no beat is lost.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_cost_open_list_top
	import mcol_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // node_id [15:0], node_cost [47:16]
	input  logic [1:0]  s_tuser,  // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // found [0], out_id [16:1], out_cost [48:17],
	                              // is_empty [49], overflow [50], zero [55:51]
);

	ctrl_cmd_t   cmd;
	dp_status_t  status;
	logic              found;
	logic [ID_W-1:0]   out_id;
	logic [COST_W-1:0] out_cost;
	logic              is_empty;
	logic              overflow;

	// Controller.
	mcol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	mcol_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_op        (s_tuser),
		.in_id        (s_tdata[15:0]),
		.in_cost      (s_tdata[47:16]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_found    (found),
		.out_id       (out_id),
		.out_cost     (out_cost),
		.out_is_empty (is_empty),
		.out_overflow (overflow)
	);

	// Pack the result beat.
	assign m_tdata = {5'b0, overflow, is_empty, out_cost, out_id, found};

endmodule

// ===== bench/tb_min_cost_open_list_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-cost open list testbench
// Drives insert, remove, extract-min and contains beats into the open list.
// Each result beat is checked against a bench shadow table or a typed reply.
// A directed table covers the empty, all-ones, tie and overflow cases. Random
// traffic follows in phases with different sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_min_cost_open_list_top;
	import mcol_pkg::*;

	localparam int TB_DEPTH     = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASES       = 4;

	// One result beat, split into its fields.
	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   id;
		logic [COST_W-1:0] cost;
		logic              empty;
		logic              overflow;
	} reply_t;

	// One row of the directed table.
	typedef struct {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [COST_W-1:0] cost;
		bit                fixed;  // reply is typed in, not predicted
		reply_t            reply;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // node_id [15:0], node_cost [47:16]
	logic [1:0]  s_tuser;  // op [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // found [0], out_id [16:1], out_cost [48:17],
	                       // is_empty [49], overflow [50], zero [55:51]

	reply_t    pending_replies[$];
	stim_row_t directed_rows[$];
	int        errors;
	int        send_idle_pct;
	int        recv_stall_pct;

	// Shadow copy of the open list table.
	logic [ID_W-1:0]   shadow_id[TB_DEPTH];
	logic [COST_W-1:0] shadow_cost[TB_DEPTH];
	int                shadow_count;

	// Small set of ids so that removes, contains and duplicates hit often.
	logic [ID_W-1:0] id_pool[8];

	min_cost_open_list_top #(
		.DEPTH(TB_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Delete every shadow entry with the given id, keeping the order.
	function automatic void purge_entries(logic [ID_W-1:0] key);
		int wr;
		wr = 0;
		for (int rd = 0; rd < shadow_count; rd++) begin
			if (shadow_id[rd] != key) begin
				shadow_id[wr]   = shadow_id[rd];
				shadow_cost[wr] = shadow_cost[rd];
				wr++;
			end
		end
		shadow_count = wr;
	endfunction

	// Apply one operation to the shadow table and return its result beat.
	function automatic reply_t predict_open_list(op_t op, logic [ID_W-1:0] key,
	                                             logic [COST_W-1:0] cost);
		reply_t            r;
		logic [COST_W-1:0] best;
		r    = '0;
		best = COST_MAX;
		case (op)
			OP_INSERT: begin
				if (shadow_count < TB_DEPTH) begin
					shadow_id[shadow_count]   = key;
					shadow_cost[shadow_count] = cost;
					shadow_count++;
				end else begin
					r.overflow = 1'b1;
				end
			end
			OP_REMOVE: begin
				purge_entries(key);
			end
			OP_EXTRACT: begin
				// Strictly lower wins, so the earliest of equal costs stays chosen.
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_cost[i] < best) begin
						best    = shadow_cost[i];
						r.id    = shadow_id[i];
						r.found = 1'b1;
					end
				end
				if (r.found) begin
					r.cost = best;
					purge_entries(r.id);
				end
			end
			default: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_id[i] == key)
						r.found = 1'b1;
				end
			end
		endcase
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(3) != 0)
			return id_pool[$urandom_range(7)];
		return ID_W'($urandom_range(16'hFFFF));
	endfunction

	// Costs lean toward all-ones, zero and a few shared values for ties.
	function automatic logic [COST_W-1:0] pick_cost();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return COST_MAX;
		if (sel < 20)
			return '0;
		if (sel < 40)
			return COST_W'($urandom_range(3)) << 16;
		return COST_W'($urandom());
	endfunction

	function automatic void check_field(string name, logic [COST_W-1:0] want,
	                                    logic [COST_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Send one operation beat and record the result it must produce.
	task automatic send_beat(op_t op, logic [ID_W-1:0] key, logic [COST_W-1:0] cost,
	                         bit fixed, reply_t fixed_reply);
		reply_t r;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(40, 4)) @(posedge clk);
			else
				repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {cost, key};
		do @(posedge clk); while (!s_tready);
		r = predict_open_list(op, key, cost);
		pending_replies = {pending_replies, (fixed ? fixed_reply : r)};
	endtask

	// Hold the sender off until every outstanding result has arrived.
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(op_t op, logic [ID_W-1:0] key, logic [COST_W-1:0] cost,
	                       bit fixed, reply_t reply);
		stim_row_t row;
		row.op    = op;
		row.id    = key;
		row.cost  = cost;
		row.fixed = fixed;
		row.reply = reply;
		directed_rows = {directed_rows, row};
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check each result beat against the oldest expectation.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found    = m_tdata[0];
			got.id       = m_tdata[16:1];
			got.cost     = m_tdata[48:17];
			got.empty    = m_tdata[49];
			got.overflow = m_tdata[50];
			if (pending_replies.size() == 0) begin
				$error("result beat with no operation outstanding");
				errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("found", COST_W'(want.found), COST_W'(got.found));
				check_field("out_id", COST_W'(want.id), COST_W'(got.id));
				check_field("out_cost", want.cost, got.cost);
				check_field("is_empty", COST_W'(want.empty), COST_W'(got.empty));
				check_field("overflow", COST_W'(want.overflow), COST_W'(got.overflow));
			end
		end
	end

	initial begin
		reply_t no_reply;
		op_t    op;
		int     sel;
		int     sent;
		no_reply       = '0;
		errors         = 0;
		shadow_count   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_INSERT;
		m_tready <= 1'b0;

		// Empty table, all-ones cost, ties, duplicates, then a full table.
		add_row(OP_EXTRACT, 16'h0000, 32'h0000_0000, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b1, 1'b0});
		add_row(OP_CONTAINS, 16'h0000, 32'hFFFF_FFFF, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b1, 1'b0});
		add_row(OP_REMOVE, 16'hFFFF, 32'h0000_0000, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b1, 1'b0});
		add_row(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b0, 1'b0});
		add_row(OP_EXTRACT, 16'h0000, 32'h0000_0000, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b0, 1'b0});
		add_row(OP_CONTAINS, 16'hFFFF, 32'h0000_0000, 1, reply_t'{1'b1, 16'h0, 32'h0, 1'b0, 1'b0});
		add_row(OP_INSERT, 16'h0000, 32'h0000_0000, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b0, 1'b0});
		add_row(OP_INSERT, 16'h0005, 32'h0001_0000, 0, no_reply);
		add_row(OP_INSERT, 16'h0007, 32'h0000_0000, 0, no_reply);
		add_row(OP_INSERT, 16'h0005, 32'h0000_8000, 0, no_reply);
		add_row(OP_EXTRACT, 16'h0000, 32'h0000_0000, 1, reply_t'{1'b1, 16'h0, 32'h0, 1'b0, 1'b0});
		add_row(OP_EXTRACT, 16'h0000, 32'h0000_0000, 1, reply_t'{1'b1, 16'h7, 32'h0, 1'b0, 1'b0});
		add_row(OP_CONTAINS, 16'h0005, 32'h0000_0000, 0, no_reply);
		add_row(OP_REMOVE, 16'h0005, 32'h0000_0000, 0, no_reply);
		for (int i = 0; i < TB_DEPTH - 1; i++)
			add_row(OP_INSERT, 16'hAAAA ^ ID_W'(i), 32'h5555_AAAA ^ COST_W'(i << 3), 0, no_reply);
		add_row(OP_INSERT, 16'h5A5A, 32'h0000_0000, 1, reply_t'{1'b0, 16'h0, 32'h0, 1'b0, 1'b1});
		add_row(OP_EXTRACT, 16'h0000, 32'h0000_0000, 0, no_reply);
		add_row(OP_REMOVE, 16'hFFFF, 32'h0000_0000, 0, no_reply);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].id, directed_rows[i].cost,
			          directed_rows[i].fixed, directed_rows[i].reply);
		wait_for_replies();

		// Random traffic; each phase starts from a drained pipeline.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			id_pool[0] = 16'h0000;
			id_pool[1] = 16'hFFFF;
			for (int i = 2; i < 8; i++)
				id_pool[i] = ID_W'($urandom_range(16'hFFFF));
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(39) == 0) begin
					// Fill past capacity, then drain the table by extraction.
					repeat (TB_DEPTH + 2)
						send_beat(OP_INSERT, pick_id(), pick_cost(), 0, no_reply);
					repeat (TB_DEPTH + 1)
						send_beat(OP_EXTRACT, pick_id(), pick_cost(), 0, no_reply);
					sent += 2 * TB_DEPTH + 3;
				end else begin
					sel = $urandom_range(99);
					op  = (sel < 45) ? OP_INSERT :
					      (sel < 68) ? OP_EXTRACT :
					      (sel < 82) ? OP_REMOVE : OP_CONTAINS;
					send_beat(op, pick_id(), pick_cost(), 0, no_reply);
					sent++;
				end
			end
			wait_for_replies();
		end

		recv_stall_pct = 0;
		repeat (4 * TB_DEPTH + 20) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
